### rtl/ssc_pkg.sv
// Shared types and constants for the salted substitution cipher.
// No dependencies; imported by every other file of the block.
package ssc_pkg;

  localparam int DataW      = 3;
  localparam int SymW       = 6;
  localparam int KindW      = 2;
  localparam int TableDepth = 64;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = 1;

  localparam logic [DataW-1:0] MaskWide   = 3'h7;
  localparam logic [DataW-1:0] MaskNarrow = 3'h3;
  localparam logic [SymW-1:0]  SymMaskWide   = 6'h3f;
  localparam logic [SymW-1:0]  SymMaskNarrow = 6'h0f;

  typedef enum logic [KindW-1:0] {
    KindLoad    = 2'd0,
    KindProcess = 2'd1,
    KindChain   = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegSymbolMode = 1'b0,
    RegDirection  = 1'b1
  } reg_e;

  typedef logic [DataW-1:0] data_t;
  typedef logic [SymW-1:0]  sym_t;

  typedef struct packed {
    logic symbol_mode;
    logic direction;
  } cfg_t;

endpackage

### rtl/ssc_if.sv
// Handshake channels of the cipher: configuration writes, input items, results.
// Depends on ssc_pkg for field widths.
interface ssc_cfg_if import ssc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface ssc_in_if import ssc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [AddrW-1:0] index;
  logic [SymW-1:0]  entry;
  logic [DataW-1:0] plain_data;
  logic [DataW-1:0] salt;
  logic [SymW-1:0]  cipher_symbol;
  modport source (output valid, kind, index, entry, plain_data, salt, cipher_symbol,
                  input ready);
  modport sink   (input valid, kind, index, entry, plain_data, salt, cipher_symbol,
                  output ready);
endinterface

interface ssc_out_if import ssc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [SymW-1:0] value;
  modport source (output valid, value, input ready);
  modport sink   (input valid, value, output ready);
endinterface

### rtl/ssc_table.sv
// Substitution table: 64 x 6 synchronous RAM, one write and one registered read port.
// Depends on ssc_pkg.
module ssc_table import ssc_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  sym_t             wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output sym_t             rdata_o
);

  sym_t mem [TableDepth];
  sym_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ssc_cfg_regs.sv
// Configuration registers (symbol mode, direction) behind the write channel.
// Depends on ssc_pkg and ssc_cfg_if.
module ssc_cfg_regs import ssc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ssc_cfg_if.sink    cfg_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (reg_e'(cfg_i.index))
        RegSymbolMode: cfg_d.symbol_mode = cfg_i.data[0];
        RegDirection:  cfg_d.direction   = cfg_i.data[0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{symbol_mode: 1'b1, direction: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/salted_substitution_cipher_top.sv
// Salted substitution cipher top level: config regs, table RAM, read stage and result register.
// Depends on ssc_pkg, ssc_if, ssc_table and ssc_cfg_regs.
//
// Takes one item per cycle while the result register is not stalled, and gives a process item's
// result through the table RAM's registered read and then the result register. Load items
// write the table at acceptance; chain and load items give no result. The encrypt address is
// built from the chain state forwarded out of the read stage, so consecutive symbols need no
// bubble. A stalled result register holds the read stage and, through it, the input.
module salted_substitution_cipher_top import ssc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ssc_cfg_if.sink   cfg_i,
  ssc_in_if.sink    in_i,
  ssc_out_if.source out_o
);

  cfg_t  cfg;
  data_t mask;
  sym_t  sym_mask;

  logic  accept;
  logic  s1_adv;
  logic  s1_valid_q;
  logic [KindW-1:0] s1_kind_q;
  data_t s1_data_q, s1_salt_q;

  data_t chain_data_q, chain_data_d, chain_salt_q, chain_salt_d;
  sym_t  rdata, ds;
  data_t cs, cd, dec_d, dec_s;

  data_t in_d, in_s, fwd_d, fwd_s, enc_hi, enc_lo;
  sym_t  enc_addr, dec_addr;
  logic [AddrW-1:0] raddr;

  logic  out_valid_q;
  sym_t  out_value_q;

  ssc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  assign mask     = cfg.symbol_mode ? MaskWide : MaskNarrow;
  assign sym_mask = cfg.symbol_mode ? SymMaskWide : SymMaskNarrow;

  assign s1_adv     = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign accept     = in_i.valid && in_i.ready;

  // read stage: undo chaining on decrypt
  assign ds    = rdata & sym_mask;
  assign cs    = chain_salt_q & mask;
  assign cd    = chain_data_q & mask;
  assign dec_d = (cfg.symbol_mode ? ds[5:3] : {1'b0, ds[3:2]}) ^ cs;
  assign dec_s = (cfg.symbol_mode ? ds[2:0] : {1'b0, ds[1:0]}) ^ cd;

  always_comb begin
    chain_data_d = chain_data_q;
    chain_salt_d = chain_salt_q;
    if (s1_valid_q && s1_adv) begin
      if (s1_kind_q == KindChain) begin
        chain_data_d = s1_data_q;
        chain_salt_d = s1_salt_q;
      end else if (s1_kind_q == KindProcess) begin
        chain_data_d = cfg.direction ? dec_d : s1_data_q;
        chain_salt_d = cfg.direction ? dec_s : s1_salt_q;
      end
    end
  end

  // accept stage: table address, chain forwarded from the read stage
  assign in_d   = in_i.plain_data & mask;
  assign in_s   = in_i.salt & mask;
  assign fwd_d  = chain_data_d & mask;
  assign fwd_s  = chain_salt_d & mask;
  assign enc_hi = in_d ^ fwd_s;
  assign enc_lo = in_s ^ fwd_d;
  assign enc_addr = cfg.symbol_mode ? {enc_hi, enc_lo} : {2'b00, enc_hi[1:0], enc_lo[1:0]};
  assign dec_addr = in_i.cipher_symbol & sym_mask;
  assign raddr    = cfg.direction ? dec_addr : enc_addr;

  ssc_table u_table (
    .clk_i   (clk_i),
    .we_i    (accept && (in_i.kind == KindLoad)),
    .waddr_i (in_i.index),
    .wdata_i (in_i.entry),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      chain_data_q <= '0;
      chain_salt_q <= '0;
    end else begin
      chain_data_q <= chain_data_d;
      chain_salt_q <= chain_salt_d;
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q && (s1_kind_q == KindProcess);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q <= in_i.kind;
      s1_data_q <= (in_i.kind == KindChain) ? in_i.plain_data : in_d;
      s1_salt_q <= (in_i.kind == KindChain) ? in_i.salt : in_s;
    end
    if (s1_adv && s1_valid_q && (s1_kind_q == KindProcess)) begin
      out_value_q <= cfg.direction ? {3'b000, dec_d} : ds;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.value = out_value_q;

endmodule

### rtl/ssc_checker.sv
// Port-level checks for the salted substitution cipher, bound to the top level.
// Depends on ssc_pkg and salted_substitution_cipher_top.
module ssc_checker import ssc_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_valid_i,
  input logic                cfg_ready_i,
  input logic [CfgIdxW-1:0]  cfg_index_i,
  input logic [CfgDataW-1:0] cfg_data_i,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [SymW-1:0]     out_value_i
);

  logic mode_q, dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
      dir_q  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_i) begin
      if (cfg_index_i == RegSymbolMode) begin
        mode_q <= cfg_data_i[0];
      end
      if (cfg_index_i == RegDirection) begin
        dir_q <= cfg_data_i[0];
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i))
    else $error("result beat dropped or changed while stalled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no result waiting");

  a_dec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && dir_q |-> out_value_i[5:3] == 3'b000)
    else $error("decrypted value wider than data field");

  a_narrow_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !mode_q |-> out_value_i[5:4] == 2'b00)
    else $error("narrow mode result exceeds 4 bits");

endmodule

bind salted_substitution_cipher_top ssc_checker u_ssc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready),
  .cfg_index_i (cfg_i.index),
  .cfg_data_i  (cfg_i.data),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.value)
);
